/* hw/rtl/ftsid_pkg.sv */
package ftsid_pkg;

  typedef enum logic [2:0] {
    REQ_SEEK    = 3'd0,
    REQ_READ_ID = 3'd1,
    REQ_READ    = 3'd2,
    REQ_DIAG    = 3'd3,
    REQ_WRITE   = 3'd4,
    REQ_FORMAT  = 3'd5
  } req_type_e;

  localparam logic [7:0] StatA0 = 8'ha0;
  localparam logic [7:0] StatB0 = 8'hb0;
  localparam logic [7:0] StatF0 = 8'hf0;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] drive;
    logic [7:0] track;
    logic [7:0] req_c;
    logic [7:0] req_h;
    logic [7:0] req_r;
    logic [7:0] req_n;
    logic       deleted;
    logic [7:0] sector_status;
    logic       first_entry;
  } req_t;

  typedef struct packed {
    logic [4:0] result_code;
    logic [7:0] ret_c;
    logic [7:0] ret_h;
    logic [7:0] ret_r;
    logic [7:0] ret_n;
    logic [4:0] slot;
  } rsp_t;

  function automatic logic [4:0] flag_code(logic [8:0] f);
    logic [4:0] c;
    c = 5'd1;
    c[1] = f[8];
    c[2] = (f[7:0] == StatA0);
    c[3] = (f[7:0] == StatB0);
    c[4] = (f[7:0] == StatF0);
    return c;
  endfunction

endpackage

/* hw/rtl/ftsid_sector_mem.sv */
module ftsid_sector_mem import ftsid_pkg::*; #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [40:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [40:0]      rdata_o
);

  // {deleted, status, C, H, R, N}
  logic [40:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/ftsid_count_mem.sv */
module ftsid_count_mem import ftsid_pkg::*; #(
  parameter int unsigned Depth = 656,
  parameter int unsigned AddrW = 10,
  parameter int unsigned CntW  = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [CntW-1:0]  wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [CntW-1:0]  rdata_o
);

  logic [CntW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/floppy_track_sector_id_table.sv */
// Sector-ID table for up to four emulated floppy drives.
// Request channel (req_*): one request carries a type (seek, read id, read,
// read diag, write, format entry), a drive, a track and a CHRN id.
// Response channel (rsp_*): exactly one result per request: result code,
// the id and the slot index for an external sector data memory.
// Both channels are valid/ready. One request is handled at a time.
// States passed from the accepting edge to response valid: format and rejected
// requests pass ST_CNT and ST_FETCH; seek, read id and diag add ST_DATA and
// ST_SCAN. Read and write scan the track's ids one per cycle through the id
// memory read port in ST_SCAN and answer on the first hit, or on a miss after
// the last of the track's count entries (at most MAX_SECTORS). The block goes
// back to idle on the edge that takes the response and can accept the next
// request at the next edge.
// After reset the per-track sector counts are cleared by a pass that writes
// zero to one count entry per cycle over all DRIVES*TRACKS entries; during
// it req_ready_o stays low. Write protect is to be written by the user via
// wp_we_i between requests, while nothing is in flight; the block itself
// does not enforce this. The response is held in an output register; while
// the receiver stalls the block holds it and accepts no new request.
module floppy_track_sector_id_table import ftsid_pkg::*; #(
  parameter int unsigned DRIVES      = 4,
  parameter int unsigned TRACKS      = 164,
  parameter int unsigned MAX_SECTORS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wp_we_i,
  input  logic [3:0]        wp_wdata_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output rsp_t              rsp_o
);

  localparam int unsigned NTrk  = DRIVES * TRACKS;
  localparam int unsigned TixW  = $clog2(NTrk + 1);
  localparam int unsigned SlotW = $clog2(MAX_SECTORS);
  localparam int unsigned SW    = (SlotW < 1) ? 1 : SlotW;
  localparam int unsigned CntW  = $clog2(MAX_SECTORS + 1);
  localparam int unsigned MemD  = NTrk * MAX_SECTORS;
  localparam int unsigned MemW  = $clog2(MemD + 1);
  localparam logic [7:0]  LastTrack = 8'(TRACKS - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_CNT   = 7'b0000100,
    ST_FETCH = 7'b0001000,
    ST_DATA  = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [3:0]      wp_q;
  req_t            req_q;
  logic [TixW-1:0] clr_q;
  logic [7:0]      sel_trk_q [DRIVES];
  logic            trk_vld_q [DRIVES];
  logic [SW-1:0]   cur_q     [DRIVES];
  logic [SW-1:0]   idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  rsp_t            rsp_q, rsp_d;
  logic            upd_q, upd_d;

  // memory ports
  logic            cw_e;
  logic [TixW-1:0] cw_a, cr_a;
  logic [CntW-1:0] cw_d, cr_d;
  logic            sw_e;
  logic [MemW-1:0] sw_a, sr_a;
  logic [40:0]     sw_d, sr_d;

  ftsid_count_mem #(.Depth(NTrk), .AddrW(TixW), .CntW(CntW)) u_cnt (
    .clk_i, .we_i(cw_e), .waddr_i(cw_a), .wdata_i(cw_d), .raddr_i(cr_a), .rdata_o(cr_d)
  );
  ftsid_sector_mem #(.Depth(MemD), .AddrW(MemW)) u_sec (
    .clk_i, .we_i(sw_e), .waddr_i(sw_a), .wdata_i(sw_d), .raddr_i(sr_a), .rdata_o(sr_d)
  );

  logic [1:0]      drv;
  logic            drv_ok;
  logic [7:0]      trk_use;
  logic [TixW-1:0] tix;
  logic [MemW-1:0] base;
  logic [31:0]     rid;
  logic            is_first;
  logic [CntW-1:0] cnt_eff;

  assign drv     = req_q.drive;
  assign drv_ok  = 32'(drv) < DRIVES;
  assign trk_use = (req_q.req_type == REQ_SEEK || req_q.req_type == REQ_FORMAT) ?
                   req_q.track : sel_trk_q[drv];
  assign tix     = TixW'(32'(drv) * TRACKS + 32'(trk_use));
  assign base    = MemW'(32'(tix) * MAX_SECTORS);
  assign rid     = {req_q.req_c, req_q.req_h, req_q.req_r, req_q.req_n};
  assign is_first = req_q.first_entry;
  assign cnt_eff  = is_first ? '0 : cr_d;

  function automatic logic [SW-1:0] next_slot(logic [SW-1:0] s, logic [CntW-1:0] c);
    return (CntW'(s) + 1'b1 < c) ? SW'(s + 1'b1) : '0;
  endfunction

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    rsp_d   = rsp_q;
    upd_d   = 1'b0;
    cw_e    = 1'b0;
    cw_a    = tix;
    cw_d    = '0;
    cr_a    = tix;
    sw_e    = 1'b0;
    sw_a    = base + MemW'(cnt_eff);
    sw_d    = {req_q.deleted, req_q.sector_status, rid};
    sr_a    = base + MemW'(idx_q);
    unique case (state_q)
      ST_CLEAR: begin
        cw_e = 1'b1;
        cw_a = clr_q;
        if (32'(clr_q) == NTrk - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_CNT;
      end
      ST_CNT: begin
        // count read issued by cr_a = tix
        rsp_d = '0;
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        cnt_d = cr_d;
        idx_d = '0;
        state_d = ST_RESP;
        if (!drv_ok) begin
        end else begin
          case (req_q.req_type)
            REQ_SEEK: if (req_q.track <= LastTrack && cr_d != '0) begin
              upd_d = 1'b1;
              if (!trk_vld_q[drv] || sel_trk_q[drv] != req_q.track) idx_d = '0;
              else idx_d = (CntW'(cur_q[drv]) >= cr_d) ? '0 : cur_q[drv];
              state_d = ST_DATA;
            end
            REQ_FORMAT: if (req_q.track <= LastTrack && 32'(cnt_eff) < MAX_SECTORS) begin
              sw_e = 1'b1;
              cw_e = 1'b1;
              cw_d = cnt_eff + 1'b1;
              upd_d = 1'b1;
              rsp_d = '{result_code: 5'd1, ret_c: req_q.req_c, ret_h: req_q.req_h,
                        ret_r: req_q.req_r, ret_n: req_q.req_n, slot: 5'(cnt_eff)};
            end
            REQ_READ_ID, REQ_DIAG: if (trk_vld_q[drv] && cr_d != '0) begin
              idx_d = (CntW'(cur_q[drv]) >= cr_d) ? '0 : cur_q[drv];
              state_d = ST_DATA;
            end
            REQ_READ, REQ_WRITE: if (trk_vld_q[drv] && cr_d != '0 &&
                !(req_q.req_type == REQ_WRITE && wp_q[drv])) begin
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_DATA: begin
        // read issued last cycle? issue now, result next cycle
        state_d = ST_SCAN;
        upd_d = upd_q;
      end
      ST_SCAN: begin
        // sr_d holds entry idx_q, read issued the previous cycle (for read/write only once upd_q is set)
        upd_d = upd_q;
        if (req_q.req_type == REQ_READ || req_q.req_type == REQ_WRITE) begin
          if (!upd_q) begin
            upd_d = 1'b1; // first cycle: read in flight
          end else if (sr_d[31:0] == rid) begin
            rsp_d = '{result_code: (req_q.req_type == REQ_WRITE) ? 5'd1 : flag_code(sr_d[40:32]),
                      ret_c: rid[31:24], ret_h: rid[23:16], ret_r: rid[15:8],
                      ret_n: rid[7:0], slot: 5'(idx_q)};
            if (req_q.req_type == REQ_WRITE) begin
              sw_e = 1'b1;
              sw_a = base + MemW'(idx_q);
              sw_d = {req_q.deleted, sr_d[39:0]};
            end
            state_d = ST_RESP;
          end else if (CntW'(idx_q) + 1'b1 >= cnt_q) begin
            state_d = ST_RESP;
          end else begin
            idx_d = SW'(idx_q + 1'b1);
            sr_a  = base + MemW'(idx_d);
            upd_d = 1'b1;
          end
          if (!upd_q) upd_d = 1'b1;
        end else begin
          rsp_d = '{result_code: (req_q.req_type == REQ_SEEK) ? 5'd1 : flag_code(sr_d[40:32]),
                    ret_c: sr_d[31:24], ret_h: sr_d[23:16], ret_r: sr_d[15:8],
                    ret_n: sr_d[7:0], slot: 5'(idx_q)};
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // read/write scan: upd_q marks that sr_d is valid for idx_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      upd_q   <= 1'b0;
      for (int d = 0; d < DRIVES; d++) begin
        sel_trk_q[d] <= '0;
        trk_vld_q[d] <= 1'b0;
        cur_q[d]     <= '0;
      end
    end else begin
      state_q <= state_d;
      upd_q   <= (state_q == ST_FETCH) ? 1'b0 : upd_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (wp_we_i) wp_q <= wp_wdata_i;
      if (state_q == ST_FETCH && upd_d) begin
        sel_trk_q[drv] <= req_q.track;
        trk_vld_q[drv] <= 1'b1;
        if (req_q.req_type == REQ_FORMAT) cur_q[drv] <= '0;
        else cur_q[drv] <= idx_d;
      end
      if (state_q == ST_SCAN && (req_q.req_type == REQ_READ_ID ||
          req_q.req_type == REQ_DIAG)) begin
        cur_q[drv] <= next_slot(idx_q, cnt_q);
      end
      if (state_q == ST_SCAN && (req_q.req_type == REQ_READ ||
          req_q.req_type == REQ_WRITE) && upd_q && state_d == ST_RESP) begin
        cur_q[drv] <= (sr_d[31:0] == rid) ? next_slot(idx_q, cnt_q) : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    rsp_q <= rsp_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_RESP);
  assign rsp_o       = rsp_q;

endmodule
